FILE: hw/rtl/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg
// shared constants and codes for the perceptron branch predictor
// ----------------------------------------------------------------------------
package pbp_pkg;

  localparam int unsigned DEF_INDEX_BITS  = 5;
  localparam int unsigned DEF_GLOBAL_LEN  = 5;
  localparam int unsigned DEF_LOCAL_LEN   = 26;
  localparam int unsigned DEF_WEIGHT_BITS = 8;

  // weights per perceptron: bias, global history weights, local history weights
  localparam int unsigned DEF_NUM_W    = 1 + DEF_GLOBAL_LEN + DEF_LOCAL_LEN;
  // one table row: all weights of a perceptron plus its local history
  localparam int unsigned DEF_ROW_BITS = DEF_NUM_W * DEF_WEIGHT_BITS + DEF_LOCAL_LEN;
  localparam int unsigned DEF_SUM_BITS = DEF_WEIGHT_BITS + $clog2(DEF_NUM_W) + 1;

  localparam int unsigned PC_BITS      = 32;
  localparam int unsigned OUT_SUM_BITS = 13;
  localparam int          OUT_SUM_MAX  = 2 ** (OUT_SUM_BITS - 1) - 1;

  // terms added per partial sum in the first adder stage
  localparam int unsigned GROUP_SIZE = 8;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

endpackage

FILE: hw/rtl/pbp_table.sv
// ----------------------------------------------------------------------------
// pbp_table
// perceptron row memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module pbp_table import pbp_pkg::*; #(
  parameter int unsigned ADDR_BITS = DEF_INDEX_BITS,
  parameter int unsigned ROW_BITS  = DEF_ROW_BITS
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [ROW_BITS-1:0]  rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [ROW_BITS-1:0]  wr_data
);

  logic [ROW_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/pbp_sum.sv
// ----------------------------------------------------------------------------
// pbp_sum
// two-level adder tree: registered partial sums, then their total
// ----------------------------------------------------------------------------
module pbp_sum import pbp_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int unsigned NUM_W       = DEF_NUM_W,
  parameter int unsigned SUM_BITS    = DEF_SUM_BITS
) (
  input  logic                              clk,
  input  logic [NUM_W*WEIGHT_BITS-1:0]      weights,
  input  logic [NUM_W-1:0]                  pos,
  output logic signed [SUM_BITS-1:0]        sum
);

  localparam int unsigned NUM_GRP = (NUM_W + GROUP_SIZE - 1) / GROUP_SIZE;

  logic signed [SUM_BITS-1:0] grp_sum      [NUM_GRP];
  logic signed [SUM_BITS-1:0] grp_sum_next [NUM_GRP];

  // add the weight where its history bit is set, subtract it otherwise
  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    w = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_sum_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < NUM_W) begin
          w = signed'(weights[(g * GROUP_SIZE + k) * WEIGHT_BITS +: WEIGHT_BITS]);
          if (pos[g * GROUP_SIZE + k]) begin
            grp_sum_next[g] = grp_sum_next[g] + SUM_BITS'(w);
          end else begin
            grp_sum_next[g] = grp_sum_next[g] - SUM_BITS'(w);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_sum[g] <= grp_sum_next[g];
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      sum = sum + grp_sum[g];
    end
  end

endmodule

FILE: hw/rtl/pbp_update.sv
// ----------------------------------------------------------------------------
// pbp_update
// training step: every weight of a row moves one step and saturates
// ----------------------------------------------------------------------------
module pbp_update import pbp_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int unsigned NUM_W       = DEF_NUM_W
) (
  input  logic [NUM_W*WEIGHT_BITS-1:0] weights,
  input  logic [NUM_W-1:0]             pos,
  input  logic                         outcome,
  output logic [NUM_W*WEIGHT_BITS-1:0] weights_next
);

  localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  logic [NUM_W-1:0] up;

  function automatic logic [WEIGHT_BITS-1:0] nudge(input logic [WEIGHT_BITS-1:0] w,
                                                   input logic up_dir);
    if (up_dir) begin
      nudge = (w == W_MAX) ? w : w + 1'b1;
    end else begin
      nudge = (w == W_MIN) ? w : w - 1'b1;
    end
  endfunction

  // up where the history bit agrees with the outcome; bias bit is always set
  assign up = ~(pos ^ {NUM_W{outcome}});

  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      weights_next[k*WEIGHT_BITS +: WEIGHT_BITS] =
        nudge(weights[k*WEIGHT_BITS +: WEIGHT_BITS], up[k]);
    end
  end

endmodule

FILE: hw/rtl/perceptron_branch_predictor.sv
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// perceptron predictor with global and per-entry local history
// ----------------------------------------------------------------------------
// usage
//   a command word is taken on a rising edge with start high and busy low:
//   opcode picks predict (index from the low bits of branch_pc) or train
//   (the entry of the last predict, using branch_outcome)
//   a predict gives one result word on predict_taken and weight_sum, with
//   done high for exactly one cycle; a train gives no result
// sequence
//   predict: row read, partial sums, then final sum and saturation into the
//   registered result; busy is already low in the cycle with done high, and
//   a new word is not taken while a predict is still in flight
//   train: row read, then write-back of the updated row
//   the single row memory with its registered read sets this order
// reset
//   rst is synchronous; after it a clearing pass writes zero to every row,
//   all 2**INDEX_BITS of them (32 by default), with busy high throughout
//   the receiver cannot hold off results: a result word lasts one cycle
// ----------------------------------------------------------------------------
module perceptron_branch_predictor import pbp_pkg::*; #(
  parameter int unsigned INDEX_BITS  = DEF_INDEX_BITS,
  parameter int unsigned GLOBAL_LEN  = DEF_GLOBAL_LEN,
  parameter int unsigned LOCAL_LEN   = DEF_LOCAL_LEN,
  parameter int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic [PC_BITS-1:0]             branch_pc,
  input  logic                           branch_outcome,
  output logic                           done,
  output logic                           predict_taken,
  output logic signed [OUT_SUM_BITS-1:0] weight_sum
);

  // row layout: weight 0 is the bias, then global weights, then local
  // weights; local history sits above the weights
  localparam int unsigned NUM_W     = 1 + GLOBAL_LEN + LOCAL_LEN;
  localparam int unsigned WROW_BITS = NUM_W * WEIGHT_BITS;
  localparam int unsigned ROW_BITS  = WROW_BITS + LOCAL_LEN;
  localparam int unsigned SUM_BITS  = WEIGHT_BITS + $clog2(NUM_W) + 1;
  localparam int unsigned EXT_BITS  = (SUM_BITS > OUT_SUM_BITS) ? SUM_BITS : OUT_SUM_BITS;
  localparam logic signed [EXT_BITS-1:0] EXT_MAX = EXT_BITS'(OUT_SUM_MAX);
  localparam logic signed [EXT_BITS-1:0] EXT_MIN = EXT_BITS'(-OUT_SUM_MAX - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_SUM,
    S_UPD
  } state_t;

  state_t                  state;
  logic [INDEX_BITS-1:0]   clr_addr;
  logic [INDEX_BITS-1:0]   last_index;
  logic [GLOBAL_LEN-1:0]   global_history;
  logic                    outcome_q;

  logic                    accept;
  logic                    rd_en;
  logic [INDEX_BITS-1:0]   rd_addr;
  logic [ROW_BITS-1:0]     rd_data;
  logic                    wr_en;
  logic [INDEX_BITS-1:0]   wr_addr;
  logic [ROW_BITS-1:0]     wr_data;

  logic [WROW_BITS-1:0]    row_weights;
  logic [LOCAL_LEN-1:0]    row_lhist;
  logic [NUM_W-1:0]        pos;
  logic [WROW_BITS-1:0]    weights_next;
  logic [LOCAL_LEN-1:0]    lhist_next;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [EXT_BITS-1:0] sum_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // read port: a predict reads the addressed row, a train the remembered one
  assign rd_en   = accept;
  assign rd_addr = (opcode == OP_TRAIN) ? last_index : branch_pc[INDEX_BITS-1:0];

  // write port: zero rows during the clearing pass, updated row on train
  assign wr_en   = (state == S_CLEAR) || (state == S_UPD);
  assign wr_addr = (state == S_CLEAR) ? clr_addr : last_index;
  assign wr_data = (state == S_CLEAR) ? '0 : {lhist_next, weights_next};

  assign row_weights = rd_data[WROW_BITS-1:0];
  assign row_lhist   = rd_data[ROW_BITS-1 -: LOCAL_LEN];

  // sign select per weight: bias always adds, history weights follow their bit
  assign pos        = {row_lhist, global_history, 1'b1};
  assign lhist_next = LOCAL_LEN'({row_lhist, outcome_q});

  pbp_table #(
    .ADDR_BITS (INDEX_BITS),
    .ROW_BITS  (ROW_BITS)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pbp_sum #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .NUM_W       (NUM_W),
    .SUM_BITS    (SUM_BITS)
  ) u_sum (
    .clk     (clk),
    .weights (row_weights),
    .pos     (pos),
    .sum     (sum)
  );

  pbp_update #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .NUM_W       (NUM_W)
  ) u_update (
    .weights      (row_weights),
    .pos          (pos),
    .outcome      (outcome_q),
    .weights_next (weights_next)
  );

  // full sum widened so the output limits always fit
  assign sum_ext = EXT_BITS'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      last_index     <= '0;
      global_history <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            outcome_q <= branch_outcome;
            if (opcode == OP_TRAIN) begin
              state <= S_UPD;
            end else begin
              last_index <= branch_pc[INDEX_BITS-1:0];
              state      <= S_CALC;
            end
          end
        end
        S_CALC: begin
          // row data valid here, partial sums load at this edge
          state <= S_SUM;
        end
        S_SUM: begin
          predict_taken <= !sum[SUM_BITS-1];
          if (sum_ext > EXT_MAX) begin
            weight_sum <= OUT_SUM_BITS'(EXT_MAX);
          end else if (sum_ext < EXT_MIN) begin
            weight_sum <= OUT_SUM_BITS'(EXT_MIN);
          end else begin
            weight_sum <= OUT_SUM_BITS'(sum_ext);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_UPD: begin
          // updated row goes back to memory at this edge
          global_history <= GLOBAL_LEN'({global_history, outcome_q});
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_from_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_SUM))
    else $error("result word without a completed sum");

  a_taken_matches_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> (predict_taken == !weight_sum[OUT_SUM_BITS-1]))
    else $error("prediction disagrees with sign of weight sum");

  a_train_writes_back: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_TRAIN) |=> wr_en)
    else $error("train word not written back");

  a_predict_no_write: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_PREDICT) |=> !wr_en ##1 !done ##1 done)
    else $error("predict word wrote the table or missed its result slot");
`endif

endmodule
